FILE: rtl/core/zrlp_pkg.sv
`timescale 1ns / 1ps
package zrlp_pkg;

  localparam logic [1:0] KIND_NAME    = 2'd0;
  localparam logic [1:0] KIND_CONTENT = 2'd1;
  localparam logic [1:0] KIND_RECORD  = 2'd2;
  localparam logic [1:0] KIND_TEXT    = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SEP  = 3'd1;
  localparam logic [2:0] ST_BAD_VAL  = 3'd2;
  localparam logic [2:0] ST_TWO_SOA  = 3'd3;
  localparam logic [2:0] ST_NO_SOA   = 3'd4;

  localparam logic [2:0] FLD_NAME    = 3'd0;
  localparam logic [2:0] FLD_TYPE    = 3'd1;
  localparam logic [2:0] FLD_TTL     = 3'd2;
  localparam logic [2:0] FLD_CONTENT = 3'd3;
  localparam logic [2:0] FLD_EXTRA   = 3'd4;

  localparam logic [1:0] TTL_SKIP   = 2'd0;
  localparam logic [1:0] TTL_DIGITS = 2'd1;
  localparam logic [1:0] TTL_DONE   = 2'd2;

  localparam logic [4:0] RT_NONE  = 5'd0;
  localparam logic [4:0] RT_A     = 5'd1;
  localparam logic [4:0] RT_NS    = 5'd2;
  localparam logic [4:0] RT_CNAME = 5'd5;
  localparam logic [4:0] RT_SOA   = 5'd6;
  localparam logic [4:0] RT_TXT   = 5'd16;
  localparam logic [4:0] RT_AAAA  = 5'd28;

  localparam logic [7:0] CH_NEWLINE   = 8'h0a;
  localparam logic [7:0] CH_SEMICOLON = 8'h3b;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_MINUS     = 8'h2d;
  localparam logic [7:0] CH_PLUS      = 8'h2b;
  localparam logic [7:0] CH_DOT       = 8'h2e;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [0:0] REG_NAME_LIMIT  = 1'd0;
  localparam logic [0:0] REG_LABEL_LIMIT = 1'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [4:0]  rtype;
    logic [31:0] ttl;
    logic [2:0]  status;
  } result_t;

  typedef struct packed {
    logic [1:0]       count;
    result_t [2:0]    res;
  } bundle_t;

endpackage

FILE: rtl/core/zrlp_core.sv
`timescale 1ns / 1ps
module zrlp_core import zrlp_pkg::*; #(
  parameter int TYPE_WORD_CHARS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  text_byte,
  input  logic        final_byte,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output bundle_t     bundle
);

  localparam int CW = $clog2(TYPE_WORD_CHARS + 1);

  logic [7:0] name_limit;
  logic [5:0] label_limit;
  logic prev_was_backslash, name_invalid, type_overlong, ttl_negative;
  logic ttl_nonempty, soa_seen, held_backslash;
  logic [2:0] field_index, sticky_error;
  logic [8:0] name_length;
  logic [6:0] label_length;
  logic [TYPE_WORD_CHARS-1:0][7:0] type_chars;
  logic [CW-1:0] type_char_count;
  logic [31:0] ttl_value;
  logic [1:0] ttl_phase;

  logic pwb_next, ni_next, to_next, tn_next, tne_next, soa_next, hb_next;
  logic [2:0] fi_next, se_next;
  logic [8:0] nl_next;
  logic [6:0] ll_next;
  logic [TYPE_WORD_CHARS-1:0][7:0] tc_next;
  logic [CW-1:0] tcc_next;
  logic [31:0] tv_next;
  logic [1:0] tp_next;

  function automatic logic [4:0] match_type(
    input logic [TYPE_WORD_CHARS-1:0][7:0] c, input logic [CW-1:0] n, input logic over);
    logic [4:0] t;
    t = RT_NONE;
    if (!over) begin
      if (n == CW'(1) && c[0] == "A") t = RT_A;
      else if (n == CW'(4) && c[0] == "A" && c[1] == "A" && c[2] == "A" && c[3] == "A")
        t = RT_AAAA;
      else if (n == CW'(5) && c[0] == "C" && c[1] == "N" && c[2] == "A" && c[3] == "M"
               && c[4] == "E")
        t = RT_CNAME;
      else if (n == CW'(2) && c[0] == "N" && c[1] == "S") t = RT_NS;
      else if (n == CW'(3) && c[0] == "S" && c[1] == "O" && c[2] == "A") t = RT_SOA;
      else if (n == CW'(3) && c[0] == "T" && c[1] == "X" && c[2] == "T") t = RT_TXT;
    end
    return t;
  endfunction

  always_comb begin
    logic esc, digit;
    logic [1:0] n;
    logic [4:0] rt;
    logic [2:0] st;
    logic [3:0] dval;
    bundle = '0;
    n = 2'd0;
    esc = prev_was_backslash;
    digit = text_byte inside {["0":"9"]};
    dval = text_byte[3:0];
    rt = match_type(type_chars, type_char_count, type_overlong);
    st = ST_OK;
    pwb_next = prev_was_backslash; ni_next = name_invalid; to_next = type_overlong;
    tn_next = ttl_negative; tne_next = ttl_nonempty; soa_next = soa_seen;
    hb_next = held_backslash; fi_next = field_index; se_next = sticky_error;
    nl_next = name_length; ll_next = label_length; tc_next = type_chars;
    tcc_next = type_char_count; tv_next = ttl_value; tp_next = ttl_phase;

    if (sticky_error == ST_OK) begin
      if (!esc && text_byte == CH_NEWLINE) begin
        if (field_index != FLD_CONTENT) st = ST_BAD_SEP;
        else if (name_invalid || rt == RT_NONE) st = ST_BAD_VAL;
        else if (rt == RT_SOA && soa_seen) st = ST_TWO_SOA;
        else if (!ttl_nonempty) st = ST_BAD_VAL;
        bundle.res[n] = '{KIND_RECORD, 8'd0, rt,
                          ttl_negative ? 32'd0 - ttl_value : ttl_value, st};
        n = n + 2'd1;
        if (st != ST_OK) se_next = st;
        else if (rt == RT_SOA) soa_next = 1'b1;
        fi_next = FLD_NAME; nl_next = '0; ll_next = '0; ni_next = 1'b0;
        tc_next = '0; tcc_next = '0; to_next = 1'b0; tv_next = '0;
        tp_next = TTL_SKIP; tn_next = 1'b0; tne_next = 1'b0; hb_next = 1'b0;
      end else if (!esc && text_byte == CH_SEMICOLON) begin
        if (field_index >= FLD_CONTENT) begin
          bundle.res[n] = '{KIND_CONTENT, text_byte, 5'd0, 32'd0, ST_OK};
          n = n + 2'd1;
        end
        if (field_index < FLD_EXTRA) fi_next = field_index + 3'd1;
      end else if (field_index == FLD_NAME) begin
        if (name_length != 9'd511) nl_next = name_length + 9'd1;
        if (nl_next > {1'b0, name_limit}) ni_next = 1'b1;
        if (text_byte == CH_DOT) ll_next = '0;
        else begin
          if (label_length != 7'd127) ll_next = label_length + 7'd1;
          if (ll_next > {1'b0, label_limit} ||
              !(digit || text_byte inside {["A":"Z"], ["a":"z"], CH_MINUS}))
            ni_next = 1'b1;
        end
        bundle.res[n] = '{KIND_NAME, text_byte, 5'd0, 32'd0, ST_OK};
        n = n + 2'd1;
      end else if (field_index == FLD_TYPE) begin
        if (type_char_count < CW'(TYPE_WORD_CHARS)) begin
          tc_next[type_char_count] = text_byte;
          tcc_next = type_char_count + CW'(1);
        end else to_next = 1'b1;
      end else if (field_index == FLD_TTL) begin
        tne_next = 1'b1;
        if (ttl_phase == TTL_SKIP) begin
          if (text_byte == CH_SPACE || text_byte inside {[8'd9:8'd13]}) begin
          end else if (text_byte == CH_MINUS || text_byte == CH_PLUS) begin
            tn_next = (text_byte == CH_MINUS);
            tp_next = TTL_DIGITS;
          end else if (digit) begin
            tp_next = TTL_DIGITS;
            tv_next = (ttl_value << 3) + (ttl_value << 1) + {28'd0, dval};
          end else tp_next = TTL_DONE;
        end else if (ttl_phase == TTL_DIGITS) begin
          if (digit) tv_next = (ttl_value << 3) + (ttl_value << 1) + {28'd0, dval};
          else tp_next = TTL_DONE;
        end
      end else begin
        if (held_backslash && text_byte != CH_SEMICOLON) begin
          bundle.res[n] = '{KIND_CONTENT, CH_BACKSLASH, 5'd0, 32'd0, ST_OK};
          n = n + 2'd1;
        end
        hb_next = (text_byte == CH_BACKSLASH);
        if (!hb_next) begin
          bundle.res[n] = '{KIND_CONTENT, text_byte, 5'd0, 32'd0, ST_OK};
          n = n + 2'd1;
        end
      end
      pwb_next = (text_byte == CH_BACKSLASH);
    end

    if (final_byte) begin
      st = se_next;
      if (st == ST_OK && hb_next) begin
        bundle.res[n] = '{KIND_CONTENT, CH_BACKSLASH, 5'd0, 32'd0, ST_OK};
        n = n + 2'd1;
      end
      if (st == ST_OK && !soa_next) st = ST_NO_SOA;
      bundle.res[n] = '{KIND_TEXT, 8'd0, 5'd0, 32'd0, st};
      n = n + 2'd1;
      fi_next = FLD_NAME; nl_next = '0; ll_next = '0; ni_next = 1'b0;
      tc_next = '0; tcc_next = '0; to_next = 1'b0; tv_next = '0;
      tp_next = TTL_SKIP; tn_next = 1'b0; tne_next = 1'b0; hb_next = 1'b0;
      pwb_next = 1'b0; soa_next = 1'b0; se_next = ST_OK;
    end
    bundle.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      name_limit <= 8'd253;
      label_limit <= 6'd63;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NAME_LIMIT:  name_limit <= cfg_data;
        REG_LABEL_LIMIT: label_limit <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_was_backslash <= 1'b0; name_invalid <= 1'b0; type_overlong <= 1'b0;
      ttl_negative <= 1'b0; ttl_nonempty <= 1'b0; soa_seen <= 1'b0;
      held_backslash <= 1'b0; field_index <= FLD_NAME; sticky_error <= ST_OK;
      name_length <= '0; label_length <= '0; type_chars <= '0;
      type_char_count <= '0; ttl_value <= '0; ttl_phase <= TTL_SKIP;
    end else if (accept) begin
      prev_was_backslash <= pwb_next; name_invalid <= ni_next; type_overlong <= to_next;
      ttl_negative <= tn_next; ttl_nonempty <= tne_next; soa_seen <= soa_next;
      held_backslash <= hb_next; field_index <= fi_next; sticky_error <= se_next;
      name_length <= nl_next; label_length <= ll_next; type_chars <= tc_next;
      type_char_count <= tcc_next; ttl_value <= tv_next; ttl_phase <= tp_next;
    end
  end

endmodule

FILE: rtl/core/zrlp_outq.sv
`timescale 1ns / 1ps
module zrlp_outq import zrlp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  bundle_t  bundle,
  output logic     can_load,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  head,
  output logic     last
);

  result_t [2:0] slots;
  logic [1:0] count;
  logic [1:0] idx;
  logic drain_last;

  assign out_valid  = (count != 2'd0);
  assign head       = slots[idx];
  assign last       = (idx == count - 2'd1);
  assign drain_last = out_valid && out_ready && last;
  assign can_load   = !out_valid || drain_last;

  always_ff @(posedge clk) begin
    if (load) slots <= bundle.res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      idx <= 2'd0;
    end else if (load) begin
      count <= bundle.count;
      idx <= 2'd0;
    end else if (drain_last) begin
      count <= 2'd0;
      idx <= 2'd0;
    end else if (out_valid && out_ready) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

FILE: rtl/core/zone_record_line_parser_top.sv
`timescale 1ns / 1ps
// zone record line parser
// input channel: in_valid / in_ready with text_byte and final_byte, one text byte
// per item. each item updates the parse state in the cycle it is accepted and
// leaves zero to three result items in a small output buffer.
// output channel: out_valid / out_ready with out_kind, out_byte, record_type,
// time_to_live, status and run_end (high on the last result of an input byte).
// an accepted byte's results are registered and shown from the next cycle.
// throughput: one input item per cycle while each byte gives at most one result
// and the receiver is ready; a byte giving more results holds the input until
// the single output port has drained the buffer, one item a cycle while out_ready.
// configuration: cfg_valid / cfg_ready with cfg_index and cfg_data, always ready;
// index 0 is name_limit, index 1 label_limit.
// reset clears the parse state, empties the buffer and restores the limits.
// when the receiver stalls the buffer holds its items and in_ready stays low
// until the last of them is taken.
module zone_record_line_parser_top import zrlp_pkg::*; #(
  parameter int TYPE_WORD_CHARS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic [4:0]  record_type,
  output logic [31:0] time_to_live,
  output logic [2:0]  status,
  output logic        run_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  bundle_t bundle;
  result_t head;
  logic accept;

  assign cfg_ready = 1'b1;
  assign accept = in_valid && in_ready;

  zrlp_core #(.TYPE_WORD_CHARS(TYPE_WORD_CHARS)) u_core (
    .clk(clk), .rst(rst), .accept(accept), .text_byte(text_byte),
    .final_byte(final_byte), .cfg_write(cfg_valid && cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .bundle(bundle)
  );

  zrlp_outq u_outq (
    .clk(clk), .rst(rst), .load(accept), .bundle(bundle), .can_load(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .head(head), .last(run_end)
  );

  assign out_kind     = head.kind;
  assign out_byte     = head.data;
  assign record_type  = head.rtype;
  assign time_to_live = head.ttl;
  assign status       = head.status;

endmodule

FILE: test/tb_zone_record_line_parser_top.sv
`timescale 1ns / 1ps
module tb_zone_record_line_parser_top;
  import zrlp_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [4:0]  rtype;
    logic [31:0] ttl;
    logic [2:0]  st;
    logic        last;
  } parse_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  text_byte;
  logic        final_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [4:0]  record_type;
  logic [31:0] time_to_live;
  logic [2:0]  status;
  logic        run_end;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [7:0]  cfg_data;

  zone_record_line_parser_top dut (.*);

  parse_result_t expected_results[$];
  byte unsigned  zone_text[$];
  int            error_count = 0;
  bit            quiet_run = 0;
  int            hold_cycles = 0;

  // predictor state
  logic [7:0]  lim_name, lim_label;
  bit          p_escape, p_name_bad, p_type_long, p_ttl_neg, p_ttl_seen;
  bit          p_soa_seen, p_held_bs;
  logic [2:0]  p_field, p_sticky;
  int          p_name_len, p_label_len, p_type_cnt;
  byte unsigned p_type_word[5];
  logic [1:0]  p_ttl_phase;
  logic [31:0] p_ttl;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb_zone_record_line_parser_top: done, errors");
    $finish;
  end

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    error_count++;
  endtask

  task automatic clear_record_state();
    p_field = FLD_NAME; p_name_len = 0; p_label_len = 0; p_name_bad = 0;
    p_type_cnt = 0; p_type_long = 0; p_ttl = 0; p_ttl_phase = TTL_SKIP;
    p_ttl_neg = 0; p_ttl_seen = 0; p_held_bs = 0;
    foreach (p_type_word[k]) p_type_word[k] = 8'd0;
  endtask

  task automatic clear_text_state();
    clear_record_state();
    p_escape = 0; p_soa_seen = 0; p_sticky = ST_OK;
  endtask

  function automatic bit word_is(string w);
    if (p_type_cnt != w.len()) return 0;
    for (int k = 0; k < w.len(); k++)
      if (p_type_word[k] != w[k]) return 0;
    return 1;
  endfunction

  function automatic logic [4:0] type_code();
    if (p_type_long) return RT_NONE;
    if (word_is("A")) return RT_A;
    if (word_is("AAAA")) return RT_AAAA;
    if (word_is("CNAME")) return RT_CNAME;
    if (word_is("NS")) return RT_NS;
    if (word_is("SOA")) return RT_SOA;
    if (word_is("TXT")) return RT_TXT;
    return RT_NONE;
  endfunction

  task automatic push_result(logic [1:0] kind, logic [7:0] data, logic [4:0] rtype,
                             logic [31:0] ttl, logic [2:0] st, ref int n);
    parse_result_t r;
    r.kind = kind; r.data = data; r.rtype = rtype; r.ttl = ttl; r.st = st; r.last = 0;
    expected_results.push_back(r);
    n++;
  endtask

  task automatic predict_byte(byte unsigned b, bit fin);
    int n;
    bit esc;
    bit dig;
    logic [4:0] code;
    logic [2:0] st;
    logic [31:0] ttl;
    n = 0;
    esc = p_escape;
    dig = (b >= "0" && b <= "9");
    if (p_sticky == ST_OK) begin
      if (!esc && b == CH_NEWLINE) begin
        code = type_code();
        ttl = p_ttl_neg ? 32'd0 - p_ttl : p_ttl;
        st = ST_OK;
        if (p_field != FLD_CONTENT) st = ST_BAD_SEP;
        else if (p_name_bad || code == RT_NONE) st = ST_BAD_VAL;
        else if (code == RT_SOA && p_soa_seen) st = ST_TWO_SOA;
        else if (!p_ttl_seen) st = ST_BAD_VAL;
        push_result(KIND_RECORD, 8'd0, code, ttl, st, n);
        if (st != ST_OK) p_sticky = st;
        else if (code == RT_SOA) p_soa_seen = 1;
        clear_record_state();
      end else if (!esc && b == CH_SEMICOLON) begin
        if (p_field >= FLD_CONTENT) push_result(KIND_CONTENT, b, RT_NONE, 32'd0, ST_OK, n);
        if (p_field < FLD_EXTRA) p_field++;
      end else if (p_field == FLD_NAME) begin
        if (p_name_len < 511) p_name_len++;
        if (p_name_len > lim_name) p_name_bad = 1;
        if (b == CH_DOT) p_label_len = 0;
        else begin
          if (p_label_len < 127) p_label_len++;
          if (p_label_len > lim_label[5:0] ||
              !(dig || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == CH_MINUS))
            p_name_bad = 1;
        end
        push_result(KIND_NAME, b, RT_NONE, 32'd0, ST_OK, n);
      end else if (p_field == FLD_TYPE) begin
        if (p_type_cnt < 5) begin
          p_type_word[p_type_cnt] = b;
          p_type_cnt++;
        end else p_type_long = 1;
      end else if (p_field == FLD_TTL) begin
        p_ttl_seen = 1;
        if (p_ttl_phase == TTL_SKIP) begin
          if (b == CH_SPACE || (b >= 9 && b <= 13)) ;
          else if (b == CH_MINUS || b == CH_PLUS) begin
            p_ttl_neg = (b == CH_MINUS);
            p_ttl_phase = TTL_DIGITS;
          end else begin
            p_ttl_phase = dig ? TTL_DIGITS : TTL_DONE;
            if (dig) p_ttl = p_ttl * 10 + (b - "0");
          end
        end else if (p_ttl_phase == TTL_DIGITS) begin
          if (dig) p_ttl = p_ttl * 10 + (b - "0");
          else p_ttl_phase = TTL_DONE;
        end
      end else begin
        if (p_held_bs && b != CH_SEMICOLON)
          push_result(KIND_CONTENT, CH_BACKSLASH, RT_NONE, 32'd0, ST_OK, n);
        p_held_bs = (b == CH_BACKSLASH);
        if (!p_held_bs) push_result(KIND_CONTENT, b, RT_NONE, 32'd0, ST_OK, n);
      end
      p_escape = (b == CH_BACKSLASH);
    end
    if (fin) begin
      st = p_sticky;
      if (st == ST_OK && p_held_bs)
        push_result(KIND_CONTENT, CH_BACKSLASH, RT_NONE, 32'd0, ST_OK, n);
      if (st == ST_OK && !p_soa_seen) st = ST_NO_SOA;
      push_result(KIND_TEXT, 8'd0, RT_NONE, 32'd0, st, n);
      clear_text_state();
    end
    if (n > 0) expected_results[$].last = 1;
  endtask

  // result checker: sample at negedge, commit at the following edge
  initial begin
    bit taken;
    parse_result_t got, want;
    forever begin
      @(negedge clk);
      taken = out_valid && out_ready && !rst;
      got.kind = out_kind; got.data = out_byte; got.rtype = record_type;
      got.ttl = time_to_live; got.st = status; got.last = run_end;
      @(posedge clk);
      if (taken) begin
        if (expected_results.size() == 0) report_mismatch("result with nothing expected");
        else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d want %0d", got.kind, want.kind));
          if (got.data !== want.data)
            report_mismatch($sformatf("byte %h want %h", got.data, want.data));
          if (got.rtype !== want.rtype)
            report_mismatch($sformatf("type %0d want %0d", got.rtype, want.rtype));
          if (got.ttl !== want.ttl)
            report_mismatch($sformatf("ttl %0d want %0d", got.ttl, want.ttl));
          if (got.st !== want.st)
            report_mismatch($sformatf("status %0d want %0d", got.st, want.st));
          if (got.last !== want.last)
            report_mismatch($sformatf("run_end %0b want %0b", got.last, want.last));
        end
      end
    end
  end

  // receiver readiness
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 0;
        hold_cycles--;
      end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_ready <= 1;
      end else out_ready <= 1;
    end
  end

  task automatic send_item(byte unsigned b, bit fin);
    bit ok;
    if (!quiet_run && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1;
    text_byte <= b;
    final_byte <= fin;
    do begin
      @(negedge clk);
      ok = in_ready;
      @(posedge clk);
    end while (!ok);
    predict_byte(b, fin);
  endtask

  // in_valid is left high after a text, so texts can follow back to back
  task automatic send_text();
    foreach (zone_text[k]) send_item(zone_text[k], k == zone_text.size() - 1);
    zone_text.delete();
  endtask

  task automatic add_str(string s);
    for (int k = 0; k < s.len(); k++) zone_text.push_back(s[k]);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] val);
    bit ok;
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    if (idx == REG_NAME_LIMIT) lim_name = val;
    else lim_label = {2'b00, val[5:0]};
  endtask

  task automatic set_limits(logic [7:0] nl, logic [5:0] ll);
    wait_drained();
    write_reg(REG_NAME_LIMIT, nl);
    write_reg(REG_LABEL_LIMIT, {2'b00, ll});
    cfg_valid <= 0;
  endtask

  task automatic add_random_record(bit soa);
    string words[6] = '{"A", "AAAA", "CNAME", "NS", "SOA", "TXT"};
    string letters = "abcxyzAZ09-";
    int labels;
    labels = $urandom_range(0, 3);
    for (int l = 0; l < labels; l++) begin
      if (l > 0) zone_text.push_back(CH_DOT);
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 30) == 0) zone_text.push_back(8'($urandom_range(0, 255)));
        else zone_text.push_back(letters[$urandom_range(0, letters.len() - 1)]);
      end
    end
    zone_text.push_back(CH_SEMICOLON);
    if (soa) add_str("SOA");
    else if ($urandom_range(0, 15) == 0) add_str("AAAAAA");
    else if ($urandom_range(0, 15) == 0) add_str("Txt");
    else add_str(words[$urandom_range(0, 4) == 0 ? 4 : $urandom_range(0, 5)]);
    zone_text.push_back(CH_SEMICOLON);
    if ($urandom_range(0, 3) == 0) zone_text.push_back($urandom_range(0, 1) ? " " : "\t");
    if ($urandom_range(0, 4) == 0) zone_text.push_back($urandom_range(0, 1) ? "-" : "+");
    repeat ($urandom_range($urandom_range(0, 20) == 0 ? 0 : 1, 6))
      zone_text.push_back(8'("0" + $urandom_range(0, 9)));
    if ($urandom_range(0, 6) == 0) zone_text.push_back("x");
    if ($urandom_range(0, 25) != 0) zone_text.push_back(CH_SEMICOLON);
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 9))
        0: zone_text.push_back(CH_BACKSLASH);
        1: begin zone_text.push_back(CH_BACKSLASH); zone_text.push_back(CH_SEMICOLON); end
        2: if ($urandom_range(0, 6) == 0) zone_text.push_back(CH_SEMICOLON);
        default: zone_text.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    zone_text.push_back(CH_NEWLINE);
  endtask

  task automatic add_random_text();
    int recs;
    recs = $urandom_range(1, 2);
    for (int r = 0; r < recs; r++) add_random_record(r == 0 && $urandom_range(0, 5) != 0);
    // sometimes an unterminated tail or plain noise
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 5)) zone_text.push_back(8'($urandom_range(0, 255)));
    if (zone_text[zone_text.size() - 1] == CH_BACKSLASH && $urandom_range(0, 1))
      zone_text.push_back("q");
  endtask

  task automatic test_directed();
    add_str("z.o;SOA;36;a\\;b\\\\c\nw;NS;\t+7z;q\nc;CNAME;4294967296;\\");
    zone_text.push_back(8'hff);
    zone_text.push_back(8'h00);
    zone_text.push_back(CH_NEWLINE);
    send_text();
    add_str("a;SOA;1;x\nb;SOA;2;y\n"); send_text();
    add_str("a;SOA\n"); send_text();
    add_str("a;SOA;5;x\nq;TXT;;\\"); send_text();
  endtask

  task automatic test_limits();
    set_limits(8'd3, 6'd1);
    add_str("a.b;SOA;1;x\nab;A;1;y\n"); send_text();
  endtask

  task automatic test_random(int bytes);
    int sent;
    sent = 0;
    while (sent < bytes) begin
      add_random_text();
      sent += zone_text.size();
      send_text();
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_cycles = 60;
    add_str("s.n;SOA;9;content\n"); send_text();
    wait_drained();
  endtask

  initial begin
    rst = 1; in_valid = 0; text_byte = 0; final_byte = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    lim_name = 8'd253; lim_label = 8'd63;
    clear_text_state();
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_limits();
    set_limits(8'($urandom_range(1, 255)), 6'($urandom_range(1, 63)));
    test_random(20);
    set_limits(8'd253, 6'd63);
    test_backpressure();
    quiet_run = 1;
    test_random(20);
    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("tb_zone_record_line_parser_top: done, clean");
    else $display("tb_zone_record_line_parser_top: done, errors");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/zrlp_pkg.sv
rtl/core/zrlp_core.sv
rtl/core/zrlp_outq.sv
rtl/core/zone_record_line_parser_top.sv
test/tb_zone_record_line_parser_top.sv
